FILE: rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Concurrent assertion shorthands used by the fsc_check checker module.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is held
`define FSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also watches reset behavior
`define FSC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: rtl/fsc_pkg.sv
// ============================================================================
// fsc_pkg
// Types, constants and character helpers of the fuzzy subsequence scorer.
// ============================================================================
package fsc_pkg;

    // Sizes
    localparam int MAX_PATTERN_DEF = 64;
    localparam int CHAR_W          = 8;
    localparam int BIAS_W          = 8;
    localparam int POS_W           = 7;
    localparam int CNT_W           = 7;
    localparam int SCORE_W         = 11;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 16;
    localparam int QUEUE_DEPTH     = 2;

    // Saturation limits
    localparam logic [POS_W-1:0]   POS_SAT   = 7'd127;
    localparam logic [CNT_W-1:0]   CNT_SAT   = 7'd127;
    localparam logic [SCORE_W-1:0] SCORE_SAT = 11'd2047;

    // Score weights
    localparam int SCORE_EXACT  = 10;
    localparam int SCORE_BOUND  = 5;
    localparam int SCORE_PREFIX = 100;
    localparam int SCORE_EMPTY  = 1000;

    localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;

    // Request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_CAND   = 2'd2
    } req_t;

    // Classified word handed from front to back
    typedef struct packed {
        req_t              req;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } cmd_t;

    // Scan state captured on the final candidate character
    typedef struct packed {
        logic               empty;
        logic               complete;
        logic               prefix_ok;
        logic [SCORE_W-1:0] running;
        logic [CNT_W-1:0]   bound_cnt;
    } snap_t;

    function automatic logic is_upper(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    // ASCII case fold to lower case
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        return is_upper(c) ? (c + 8'd32) : c;
    endfunction

endpackage

FILE: rtl/fuzzy_subsequence_scorer.sv
// m_tvalid rises after a final candidate character passes the queue, snapshot and
// output registers. Throughput: one word per cycle unless m_tready stalls, set by
// the scan step whose next match count addresses the pattern RAM for the following word.
// Pattern, clear and unused-code words produce no result.
// Reset (aresetn low, synchronous) clears pattern length, scan state, queue and
// bias; pattern RAM contents are not cleared and need no clearing pass.
// ============================================================================
// fuzzy_subsequence_scorer
// Case-insensitive greedy subsequence matcher with position and boundary
// scoring; front classifies stream words, back runs the scan and scoring.
// ============================================================================
module fuzzy_subsequence_scorer import fsc_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] char_code
    input  logic                 s_tlast,   // last_char
    input  logic [1:0]           s_tuser,   // [1:0] req_type
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [10:0] score, [15:11] zero
    output logic [0:0]           m_tuser,   // [0] matched
    // Bias register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [BIAS_W-1:0]    cfg_data   // [7:0] score_bias
);
    logic               bias_we;
    logic [BIAS_W-1:0]  score_bias_reg;
    logic               q_full, q_valid, q_push, q_pop;
    cmd_t               push_cmd, head_cmd;
    logic               matched;
    logic [SCORE_W-1:0] score;

    // Bias register
    assign cfg_ready = 1'b1;
    assign bias_we   = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_bias_reg <= '0;
        end else if (bias_we) begin
            score_bias_reg <= cfg_data;
        end
    end

    fsc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (q_push),
        .cmd      (push_cmd)
    );

    fsc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    fsc_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_cmd      (head_cmd),
        .score_bias (score_bias_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_matched  (matched),
        .m_score    (score)
    );

    // Result packing
    assign m_tdata = {{(M_TDATA_W - SCORE_W){1'b0}}, score};
    assign m_tuser = matched;

endmodule

FILE: rtl/fsc_ram.sv
// ============================================================================
// fsc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module fsc_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read (read returns old data on collision)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/fsc_queue.sv
// ============================================================================
// fsc_queue
// Short FIFO of classified words between the front and back sections.
// ============================================================================
module fsc_queue import fsc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t head
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    cmd_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/fsc_front.sv
// ============================================================================
// fsc_front
// Input side: takes stream words, sorts them by request kind, drops unused
// codes and pushes the rest into the queue.
// ============================================================================
module fsc_front import fsc_pkg::*; (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] char_code
    input  logic                 s_tlast,
    input  logic [1:0]           s_tuser,   // [1:0] req_type
    input  logic                 q_full,
    output logic                 push,
    output cmd_t                 cmd
);
    logic accept;
    req_t req;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign req      = req_t'(s_tuser);

    // Classify; last only matters on a candidate character
    always_comb begin
        push     = 1'b0;
        cmd.req  = req;
        cmd.ch   = s_tdata[CHAR_W-1:0];
        cmd.last = 1'b0;
        case (req)
            REQ_CLEAR, REQ_APPEND: begin
                push = accept;
            end
            REQ_CAND: begin
                push     = accept;
                cmd.last = s_tlast;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/fsc_back.sv
// ============================================================================
// fsc_back
// Execution side: pattern store, greedy subsequence scan, result capture
// and final score with output register.
// ============================================================================
module fsc_back import fsc_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  cmd_t               q_cmd,
    input  logic [BIAS_W-1:0]  score_bias,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_matched,
    output logic [SCORE_W-1:0] m_score
);
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW = (LW > POS_W) ? LW : POS_W;
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN);

    // Scan state
    logic [LW-1:0]      len_reg, len_next;
    logic [LW-1:0]      mc_reg, mc_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SCORE_W-1:0] rs_reg, rs_next;
    logic               prefix_reg, prefix_next;
    logic [CNT_W-1:0]   bc_reg, bc_next;
    logic [CHAR_W-1:0]  prev_reg, prev_next;

    // Pattern store and write bypass
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [CHAR_W-1:0]  ram_rdata;
    logic               byp_valid_reg;
    logic [CHAR_W-1:0]  byp_data_reg;
    logic [CHAR_W-1:0]  cur_char;

    // Result pipeline
    logic               snap_valid_reg;
    snap_t              snap_reg, snap_next;
    logic               snap_load, snap_move, snap_free, out_free;
    logic               out_valid_reg;
    logic               out_matched_reg, out_matched_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;

    // Compare terms
    logic               active, hit, boundary, exact;
    logic [3:0]         amt;
    logic [SCORE_W:0]   rs_sum;
    logic [SCORE_W-1:0] bc_x10;
    logic [SCORE_W:0]   total;

    fsc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len_reg[AW-1:0]),
        .wdata (q_cmd.ch),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake between stages
    assign out_free  = !out_valid_reg || m_ready;
    assign snap_move = snap_valid_reg && out_free;
    assign snap_free = !snap_valid_reg || snap_move;
    assign q_pop     = q_valid && snap_free;

    // Pattern character at the current match count
    assign cur_char  = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign active    = (mc_reg < len_reg);
    assign hit       = active && (fold(q_cmd.ch) == fold(cur_char));
    assign boundary  = (pos_reg == '0) || (prev_reg == CHAR_UNDERSCORE) ||
                       (is_lower(prev_reg) && is_upper(q_cmd.ch));
    assign exact     = (CW'(pos_reg) == CW'(mc_reg));
    assign amt       = (exact ? 4'(SCORE_EXACT) : 4'd0) +
                       (boundary ? 4'(SCORE_BOUND) : 4'd0);
    assign rs_sum    = {1'b0, rs_reg} + (SCORE_W+1)'(amt);

    // Next match count addresses the store for the following word
    assign ram_raddr = mc_next[AW-1:0];

    // Scan step
    always_comb begin
        len_next    = len_reg;
        mc_next     = mc_reg;
        pos_next    = pos_reg;
        rs_next     = rs_reg;
        prefix_next = prefix_reg;
        bc_next     = bc_reg;
        prev_next   = prev_reg;
        ram_we      = 1'b0;
        snap_load   = 1'b0;
        snap_next   = snap_reg;
        if (q_pop) begin
            case (q_cmd.req)
                REQ_CLEAR, REQ_APPEND: begin
                    if (q_cmd.req == REQ_CLEAR) begin
                        len_next = '0;
                    end else if (len_reg < LEN_MAX) begin
                        ram_we   = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                    mc_next     = '0;
                    pos_next    = '0;
                    rs_next     = '0;
                    prefix_next = 1'b1;
                    bc_next     = '0;
                    prev_next   = '0;
                end
                REQ_CAND: begin
                    if (hit) begin
                        rs_next = rs_sum[SCORE_W] ? SCORE_SAT : rs_sum[SCORE_W-1:0];
                        if (boundary && (bc_reg < CNT_SAT)) begin
                            bc_next = bc_reg + 1'b1;
                        end
                        mc_next = mc_reg + 1'b1;
                    end else if (active) begin
                        prefix_next = 1'b0;
                    end
                    prev_next = q_cmd.ch;
                    if (pos_reg < POS_SAT) begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (q_cmd.last) begin
                        snap_load           = 1'b1;
                        snap_next.empty     = (len_reg == '0);
                        snap_next.complete  = (mc_next == len_reg);
                        snap_next.prefix_ok = prefix_next;
                        snap_next.running   = rs_next;
                        snap_next.bound_cnt = bc_next;
                        mc_next     = '0;
                        pos_next    = '0;
                        rs_next     = '0;
                        prefix_next = 1'b1;
                        bc_next     = '0;
                        prev_next   = '0;
                    end
                end
                default: begin
                    len_next = len_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            mc_reg        <= '0;
            pos_reg       <= '0;
            rs_reg        <= '0;
            prefix_reg    <= 1'b1;
            bc_reg        <= '0;
            prev_reg      <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            mc_reg        <= mc_next;
            pos_reg       <= pos_next;
            rs_reg        <= rs_next;
            prefix_reg    <= prefix_next;
            bc_reg        <= bc_next;
            prev_reg      <= prev_next;
            // RAM reads old data when writing the entry it reads
            byp_valid_reg <= ram_we && (len_reg[AW-1:0] == ram_raddr);
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= q_cmd.ch;
    end

    // Captured scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (snap_load) begin
            snap_valid_reg <= 1'b1;
        end else if (snap_move) begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_load) begin
            snap_reg <= snap_next;
        end
    end

    // Nonempty match: running + prefix bonus + 10/boundary + bias, saturated
    assign bc_x10 = {SCORE_W'(snap_reg.bound_cnt) << 3} + {SCORE_W'(snap_reg.bound_cnt) << 1};

    always_comb begin
        if (snap_reg.empty) begin
            total = (SCORE_W+1)'(SCORE_EMPTY) + (SCORE_W+1)'(score_bias);
        end else begin
            total = {1'b0, snap_reg.running} + {1'b0, bc_x10} +
                    (SCORE_W+1)'(score_bias) +
                    (snap_reg.prefix_ok ? (SCORE_W+1)'(SCORE_PREFIX) : '0);
        end
        out_matched_next = snap_reg.empty || snap_reg.complete;
        if (!out_matched_next) begin
            out_score_next = '0;
        end else if (total > {1'b0, SCORE_SAT}) begin
            out_score_next = SCORE_SAT;
        end else begin
            out_score_next = total[SCORE_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_move) begin
            out_matched_reg <= out_matched_next;
            out_score_reg   <= out_score_next;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_matched = out_matched_reg;
    assign m_score   = out_score_reg;

endmodule

FILE: rtl/fsc_check.sv
// ============================================================================
// fsc_check
// Port-level checks on the result stream of the fuzzy subsequence scorer.
// ============================================================================
`include "assert_macros.svh"

module fsc_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // Stalled result holds
    `FSC_ASSERT(a_hold,
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)),
        "result changed while stalled")

    // No-match results carry a zero score
    `FSC_ASSERT(a_nomatch_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata == 16'd0),
        "no-match with nonzero score")

    // Score never exceeds 11 bits
    `FSC_ASSERT(a_pad_zero, m_tvalid |-> (m_tdata[15:11] == 5'd0), "score padding not zero")

    // Reset empties the output register
    `FSC_ASSERT_RST(a_reset_idle, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind fuzzy_subsequence_scorer fsc_check u_fsc_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
